// ===== rtl/core/qvr_pkg.sv =====
// Shared widths, types and constants for the quaternion vector rotation pipeline.
package qvr_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int QUAT_FRAC_BITS = 30;
    localparam int NUM_AXES       = 3;
    localparam int NUM_STAGES     = 6;

    // pair products of quaternion components
    localparam int PROD_W   = 2 * DATA_WIDTH;
    // rotation matrix entries, up to 2^(2*DATA_WIDTH) in magnitude
    localparam int MAT_W    = 2 * DATA_WIDTH + 2;
    // matrix entry split into an unsigned low part and a signed high part
    localparam int LO_W     = DATA_WIDTH + 1;
    localparam int HI_W     = MAT_W - LO_W;
    localparam int LO_PP_W  = LO_W + 1 + DATA_WIDTH;
    localparam int HI_PP_W  = HI_W + DATA_WIDTH;
    localparam int LO_SUM_W = LO_PP_W + 2;
    localparam int HI_SUM_W = HI_PP_W + 2;
    localparam int ACC_W    = 3 * DATA_WIDTH + 3;
    localparam int RND_SHIFT = 2 * QUAT_FRAC_BITS;

    localparam int IN_TDATA_W  = 7 * DATA_WIDTH;
    localparam int OUT_TDATA_W = 3 * DATA_WIDTH;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // row-major matrix element positions
    localparam int M00 = 0;
    localparam int M01 = 1;
    localparam int M02 = 2;
    localparam int M10 = 3;
    localparam int M11 = 4;
    localparam int M12 = 5;
    localparam int M20 = 6;
    localparam int M21 = 7;
    localparam int M22 = 8;

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef t_word [NUM_AXES-1:0]         t_vec;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [MAT_W-1:0]      t_mat_elem;
    typedef t_mat_elem [NUM_AXES*NUM_AXES-1:0] t_mat;
    typedef logic signed [LO_PP_W-1:0]    t_lo_pp;
    typedef logic signed [HI_PP_W-1:0]    t_hi_pp;
    typedef logic signed [LO_SUM_W-1:0]   t_lo_sum;
    typedef logic signed [HI_SUM_W-1:0]   t_hi_sum;
    typedef logic signed [ACC_W-1:0]      t_acc;

    typedef struct packed {
        t_prod xx;
        t_prod yy;
        t_prod zz;
        t_prod ww;
        t_prod xy;
        t_prod xz;
        t_prod yz;
        t_prod wx;
        t_prod wy;
        t_prod wz;
    } t_quat_prod;

    typedef enum logic {
        MODE_FRAME   = 1'b0,
        MODE_INVERSE = 1'b1
    } t_mode;

    localparam t_word WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_acc  RND_HALF = t_acc'(1) << (RND_SHIFT - 1);

endpackage

// ===== rtl/core/qvr_quad_mul.sv =====
// Stage one: the ten pair products of the quaternion components.
module qvr_quad_mul (
    input  logic               i_clk,
    input  logic               i_ce,
    input  qvr_pkg::t_word     i_quat_x,
    input  qvr_pkg::t_word     i_quat_y,
    input  qvr_pkg::t_word     i_quat_z,
    input  qvr_pkg::t_word     i_quat_w,
    input  qvr_pkg::t_vec      i_vec,
    input  qvr_pkg::t_mode     i_mode,
    output qvr_pkg::t_quat_prod o_prod,
    output qvr_pkg::t_vec      o_vec,
    output qvr_pkg::t_mode     o_mode
);

    qvr_pkg::t_quat_prod r_prod, n_prod;
    qvr_pkg::t_vec       r_vec;
    qvr_pkg::t_mode      r_mode;

    always_comb begin
        n_prod.xx = $signed(i_quat_x) * $signed(i_quat_x);
        n_prod.yy = $signed(i_quat_y) * $signed(i_quat_y);
        n_prod.zz = $signed(i_quat_z) * $signed(i_quat_z);
        n_prod.ww = $signed(i_quat_w) * $signed(i_quat_w);
        n_prod.xy = $signed(i_quat_x) * $signed(i_quat_y);
        n_prod.xz = $signed(i_quat_x) * $signed(i_quat_z);
        n_prod.yz = $signed(i_quat_y) * $signed(i_quat_z);
        n_prod.wx = $signed(i_quat_w) * $signed(i_quat_x);
        n_prod.wy = $signed(i_quat_w) * $signed(i_quat_y);
        n_prod.wz = $signed(i_quat_w) * $signed(i_quat_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod <= n_prod;
            r_vec  <= i_vec;
            r_mode <= i_mode;
        end
    end

    assign o_prod = r_prod;
    assign o_vec  = r_vec;
    assign o_mode = r_mode;

endmodule

// ===== rtl/core/qvr_matrix.sv =====
// Stage two: rotation matrix entries from the pair products, per direction.
module qvr_matrix (
    input  logic                i_clk,
    input  logic                i_ce,
    input  qvr_pkg::t_quat_prod i_prod,
    input  qvr_pkg::t_vec       i_vec,
    input  qvr_pkg::t_mode      i_mode,
    output qvr_pkg::t_mat       o_mat,
    output qvr_pkg::t_vec       o_vec
);

    qvr_pkg::t_mat r_mat, n_mat;
    qvr_pkg::t_vec r_vec;

    qvr_pkg::t_mat_elem xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
    qvr_pkg::t_mat_elem xy_p, xy_m, xz_p, xz_m, yz_p, yz_m;

    always_comb begin
        xx = qvr_pkg::t_mat_elem'(i_prod.xx);
        yy = qvr_pkg::t_mat_elem'(i_prod.yy);
        zz = qvr_pkg::t_mat_elem'(i_prod.zz);
        ww = qvr_pkg::t_mat_elem'(i_prod.ww);
        xy = qvr_pkg::t_mat_elem'(i_prod.xy);
        xz = qvr_pkg::t_mat_elem'(i_prod.xz);
        yz = qvr_pkg::t_mat_elem'(i_prod.yz);
        wx = qvr_pkg::t_mat_elem'(i_prod.wx);
        wy = qvr_pkg::t_mat_elem'(i_prod.wy);
        wz = qvr_pkg::t_mat_elem'(i_prod.wz);

        xy_p = (xy + wz) <<< 1;
        xy_m = (xy - wz) <<< 1;
        xz_p = (xz + wy) <<< 1;
        xz_m = (xz - wy) <<< 1;
        yz_p = (yz + wx) <<< 1;
        yz_m = (yz - wx) <<< 1;

        n_mat[qvr_pkg::M00] = ww + xx - yy - zz;
        n_mat[qvr_pkg::M11] = ww - xx + yy - zz;
        n_mat[qvr_pkg::M22] = ww - xx - yy + zz;

        // the cross-product terms flip sign with the direction of rotation
        unique case (i_mode)
            qvr_pkg::MODE_INVERSE: begin
                n_mat[qvr_pkg::M01] = xy_m;
                n_mat[qvr_pkg::M10] = xy_p;
                n_mat[qvr_pkg::M02] = xz_p;
                n_mat[qvr_pkg::M20] = xz_m;
                n_mat[qvr_pkg::M12] = yz_m;
                n_mat[qvr_pkg::M21] = yz_p;
            end
            default: begin
                n_mat[qvr_pkg::M01] = xy_p;
                n_mat[qvr_pkg::M10] = xy_m;
                n_mat[qvr_pkg::M02] = xz_m;
                n_mat[qvr_pkg::M20] = xz_p;
                n_mat[qvr_pkg::M12] = yz_p;
                n_mat[qvr_pkg::M21] = yz_m;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_mat <= n_mat;
            r_vec <= i_vec;
        end
    end

    assign o_mat = r_mat;
    assign o_vec = r_vec;

endmodule

// ===== rtl/core/qvr_mat_vec.sv =====
// Stages three and four: split matrix-vector partial products and their row sums.
module qvr_mat_vec (
    input  logic             i_clk,
    input  logic [1:0]       i_ce,
    input  qvr_pkg::t_mat    i_mat,
    input  qvr_pkg::t_vec    i_vec,
    output qvr_pkg::t_lo_sum o_lo_sum [qvr_pkg::NUM_AXES],
    output qvr_pkg::t_hi_sum o_hi_sum [qvr_pkg::NUM_AXES]
);

    localparam int NUM_ELEM = qvr_pkg::NUM_AXES * qvr_pkg::NUM_AXES;

    qvr_pkg::t_lo_pp  r_pp_lo  [NUM_ELEM];
    qvr_pkg::t_hi_pp  r_pp_hi  [NUM_ELEM];
    qvr_pkg::t_lo_pp  n_pp_lo  [NUM_ELEM];
    qvr_pkg::t_hi_pp  n_pp_hi  [NUM_ELEM];
    qvr_pkg::t_lo_sum r_lo_sum [qvr_pkg::NUM_AXES];
    qvr_pkg::t_hi_sum r_hi_sum [qvr_pkg::NUM_AXES];
    qvr_pkg::t_lo_sum n_lo_sum [qvr_pkg::NUM_AXES];
    qvr_pkg::t_hi_sum n_hi_sum [qvr_pkg::NUM_AXES];

    // entry = hi * 2^LO_W + lo, lo taken unsigned
    always_comb begin
        for (int r = 0; r < qvr_pkg::NUM_AXES; r++) begin
            for (int c = 0; c < qvr_pkg::NUM_AXES; c++) begin
                n_pp_lo[r*qvr_pkg::NUM_AXES+c] =
                    $signed({1'b0, i_mat[r*qvr_pkg::NUM_AXES+c][qvr_pkg::LO_W-1:0]})
                    * $signed(i_vec[c]);
                n_pp_hi[r*qvr_pkg::NUM_AXES+c] =
                    $signed(i_mat[r*qvr_pkg::NUM_AXES+c][qvr_pkg::MAT_W-1:qvr_pkg::LO_W])
                    * $signed(i_vec[c]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < qvr_pkg::NUM_AXES; r++) begin
            n_lo_sum[r] = qvr_pkg::t_lo_sum'(r_pp_lo[r*qvr_pkg::NUM_AXES])
                        + qvr_pkg::t_lo_sum'(r_pp_lo[r*qvr_pkg::NUM_AXES+1])
                        + qvr_pkg::t_lo_sum'(r_pp_lo[r*qvr_pkg::NUM_AXES+2]);
            n_hi_sum[r] = qvr_pkg::t_hi_sum'(r_pp_hi[r*qvr_pkg::NUM_AXES])
                        + qvr_pkg::t_hi_sum'(r_pp_hi[r*qvr_pkg::NUM_AXES+1])
                        + qvr_pkg::t_hi_sum'(r_pp_hi[r*qvr_pkg::NUM_AXES+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
        end
        if (i_ce[1]) begin
            r_lo_sum <= n_lo_sum;
            r_hi_sum <= n_hi_sum;
        end
    end

    assign o_lo_sum = r_lo_sum;
    assign o_hi_sum = r_hi_sum;

endmodule

// ===== rtl/core/qvr_round_sat.sv =====
// Stages five and six: merge the split sums, round to nearest, saturate to a word.
module qvr_round_sat (
    input  logic             i_clk,
    input  logic [1:0]       i_ce,
    input  qvr_pkg::t_lo_sum i_lo_sum [qvr_pkg::NUM_AXES],
    input  qvr_pkg::t_hi_sum i_hi_sum [qvr_pkg::NUM_AXES],
    output qvr_pkg::t_vec    o_vec,
    output logic             o_sat
);

    localparam int UPPER_W = qvr_pkg::ACC_W - qvr_pkg::DATA_WIDTH + 1;

    qvr_pkg::t_acc r_acc [qvr_pkg::NUM_AXES];
    qvr_pkg::t_acc n_acc [qvr_pkg::NUM_AXES];
    qvr_pkg::t_acc shifted [qvr_pkg::NUM_AXES];
    logic [UPPER_W-1:0] upper [qvr_pkg::NUM_AXES];
    logic [qvr_pkg::NUM_AXES-1:0] ovf;
    qvr_pkg::t_vec r_vec, n_vec;
    logic          r_sat;

    always_comb begin
        for (int a = 0; a < qvr_pkg::NUM_AXES; a++) begin
            n_acc[a] = (qvr_pkg::t_acc'(i_hi_sum[a]) <<< qvr_pkg::LO_W)
                     + qvr_pkg::t_acc'(i_lo_sum[a]) + qvr_pkg::RND_HALF;
        end
    end

    always_comb begin
        for (int a = 0; a < qvr_pkg::NUM_AXES; a++) begin
            shifted[a] = r_acc[a] >>> qvr_pkg::RND_SHIFT;
            upper[a]   = shifted[a][qvr_pkg::ACC_W-1:qvr_pkg::DATA_WIDTH-1];
            // clip when the bits above the word are not all copies of its sign
            ovf[a]     = !((&upper[a]) || !(|upper[a]));
            if (ovf[a]) begin
                n_vec[a] = upper[a][UPPER_W-1] ? qvr_pkg::WORD_MIN : qvr_pkg::WORD_MAX;
            end else begin
                n_vec[a] = shifted[a][qvr_pkg::DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r_acc <= n_acc;
        end
        if (i_ce[1]) begin
            r_vec <= n_vec;
            r_sat <= |ovf;
        end
    end

    assign o_vec = r_vec;
    assign o_sat = r_sat;

endmodule

// ===== rtl/core/quaternion_vector_frame_rotation_top.sv =====
// Top level of the quaternion vector rotation pipeline with stream ports.
//
// Rotates one vector by a scalar-last Q1.30 quaternion per clock. Mode 0 gives
// the vector part of conj(q)*v*q, mode 1 that of q*v*conj(q); the quaternion is
// not normalized, so the result carries a factor |q|^2. The quaternion is first
// turned into a rotation matrix, the matrix-vector product is formed exactly,
// then rounded to nearest (ties up) and clipped to 32 bits, with tuser flagging
// any clipped component. Throughput is one word per clock while the output is not
// held off. The register stages are pair products, matrix, partial products,
// row sums, merge and round, and saturate into the output register. When the
// output is held off, words pile up in the stages, empty stages still fill, and
// the input stalls only once every stage holds a word.
module quaternion_vector_frame_rotation_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
    input  logic [qvr_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // mode
    input  logic [0:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // out_x, out_y, out_z
    output logic [qvr_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // saturated
    output logic [0:0]                         o_m_axis_tuser
);

    localparam int DW   = qvr_pkg::DATA_WIDTH;
    localparam int LAST = qvr_pkg::NUM_STAGES - 1;

    logic [qvr_pkg::NUM_STAGES-1:0] r_vld;
    logic [qvr_pkg::NUM_STAGES-1:0] rdy;

    qvr_pkg::t_vec       in_vec;
    qvr_pkg::t_quat_prod s1_prod;
    qvr_pkg::t_vec       s1_vec;
    qvr_pkg::t_mode      s1_mode;
    qvr_pkg::t_mat       s2_mat;
    qvr_pkg::t_vec       s2_vec;
    qvr_pkg::t_lo_sum    s4_lo_sum [qvr_pkg::NUM_AXES];
    qvr_pkg::t_hi_sum    s4_hi_sum [qvr_pkg::NUM_AXES];
    qvr_pkg::t_vec       out_vec;
    logic                out_sat;

    // a stage may load when it is empty or its word moves on
    always_comb begin
        rdy[LAST] = !r_vld[LAST] || i_m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < qvr_pkg::NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign in_vec[qvr_pkg::AXIS_X] = i_s_axis_tdata[5*DW-1:4*DW];
    assign in_vec[qvr_pkg::AXIS_Y] = i_s_axis_tdata[6*DW-1:5*DW];
    assign in_vec[qvr_pkg::AXIS_Z] = i_s_axis_tdata[7*DW-1:6*DW];

    qvr_quad_mul u_quad_mul (
        .i_clk    (i_clk),
        .i_ce     (rdy[0]),
        .i_quat_x (i_s_axis_tdata[DW-1:0]),
        .i_quat_y (i_s_axis_tdata[2*DW-1:DW]),
        .i_quat_z (i_s_axis_tdata[3*DW-1:2*DW]),
        .i_quat_w (i_s_axis_tdata[4*DW-1:3*DW]),
        .i_vec    (in_vec),
        .i_mode   (qvr_pkg::t_mode'(i_s_axis_tuser[0])),
        .o_prod   (s1_prod),
        .o_vec    (s1_vec),
        .o_mode   (s1_mode)
    );

    qvr_matrix u_matrix (
        .i_clk  (i_clk),
        .i_ce   (rdy[1]),
        .i_prod (s1_prod),
        .i_vec  (s1_vec),
        .i_mode (s1_mode),
        .o_mat  (s2_mat),
        .o_vec  (s2_vec)
    );

    qvr_mat_vec u_mat_vec (
        .i_clk    (i_clk),
        .i_ce     (rdy[3:2]),
        .i_mat    (s2_mat),
        .i_vec    (s2_vec),
        .o_lo_sum (s4_lo_sum),
        .o_hi_sum (s4_hi_sum)
    );

    qvr_round_sat u_round_sat (
        .i_clk    (i_clk),
        .i_ce     (rdy[5:4]),
        .i_lo_sum (s4_lo_sum),
        .i_hi_sum (s4_hi_sum),
        .o_vec    (out_vec),
        .o_sat    (out_sat)
    );

    assign o_s_axis_tready = rdy[0];
    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tdata  = out_vec;
    assign o_m_axis_tuser  = out_sat;

    logic in_acc, out_acc;
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // an accepted word with nothing leaving adds exactly one to the pipe
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !out_acc) |=> ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("pipeline occupancy did not grow by one");

    // a held stage keeps its word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_vld & $past(r_vld & ~rdy)) == $past(r_vld & ~rdy)))
        else $error("stalled stage dropped its word");

    // a clip flag always comes with a component at a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        (out_vec[qvr_pkg::AXIS_X] == qvr_pkg::WORD_MAX
         || out_vec[qvr_pkg::AXIS_X] == qvr_pkg::WORD_MIN
         || out_vec[qvr_pkg::AXIS_Y] == qvr_pkg::WORD_MAX
         || out_vec[qvr_pkg::AXIS_Y] == qvr_pkg::WORD_MIN
         || out_vec[qvr_pkg::AXIS_Z] == qvr_pkg::WORD_MAX
         || out_vec[qvr_pkg::AXIS_Z] == qvr_pkg::WORD_MIN))
        else $error("saturation flag without a clipped component");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the quaternion vector rotation pipeline with stream ports.
module tb_top;
    import qvr_pkg::*;

    localparam int EDGE_WAIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_RANDOM = 900;

    typedef logic signed [127:0] t_wide;
    typedef struct packed {
        t_wide x;
        t_wide y;
        t_wide z;
        t_wide w;
    } t_wquat;
    typedef struct packed {
        t_word qx;
        t_word qy;
        t_word qz;
        t_word qw;
        t_word vx;
        t_word vy;
        t_word vz;
        t_mode mode;
        logic  hold;
    } t_rot_item;
    typedef struct packed {
        t_word ox;
        t_word oy;
        t_word oz;
        logic  sat;
    } t_rot_result;
    typedef struct packed {
        t_word val;
        logic  clip;
    } t_axis_out;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [0:0]             s_user = '0;
    logic                   o_m_axis_tvalid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [0:0]             o_m_axis_tuser;

    t_rot_item   vectors_to_send[$];
    t_rot_result rotations_due[$];
    t_rot_item   cur_item;

    int n_errors = 0;
    int n_checked = 0;
    int n_frame = 0;
    int n_inverse = 0;
    int n_clipped = 0;
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;
    int rx_cyc = 0;
    int rx_style = 0;

    quaternion_vector_frame_rotation_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hamilton product, scalar last
    function automatic t_wquat quat_mul(input t_wquat l, input t_wquat r);
        t_wquat o;
        o.x = l.w * r.x - l.z * r.y + l.y * r.z + l.x * r.w;
        o.y = l.z * r.x - l.x * r.z + l.w * r.y + l.y * r.w;
        o.z = l.x * r.y - l.y * r.x + l.w * r.z + l.z * r.w;
        o.w = l.w * r.w - l.x * r.x - l.y * r.y - l.z * r.z;
        return o;
    endfunction

    // round to nearest, ties up, then clip to a word
    function automatic t_axis_out round_clip(input t_wide acc);
        t_wide     r;
        t_axis_out o;
        r = (acc + (t_wide'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        o.clip = 1'b1;
        if (r > t_wide'(WORD_MAX)) begin
            o.val = WORD_MAX;
        end else if (r < t_wide'(WORD_MIN)) begin
            o.val = WORD_MIN;
        end else begin
            o.val = r[DATA_WIDTH-1:0];
            o.clip = 1'b0;
        end
        return o;
    endfunction

    function automatic t_rot_result rotate_vector(input t_rot_item it);
        t_wquat      q;
        t_wquat      cj;
        t_wquat      v;
        t_wquat      prod;
        t_axis_out   ax;
        t_axis_out   ay;
        t_axis_out   az;
        t_rot_result r;
        q.x = it.qx;
        q.y = it.qy;
        q.z = it.qz;
        q.w = it.qw;
        cj.x = -q.x;
        cj.y = -q.y;
        cj.z = -q.z;
        cj.w = q.w;
        v.x = it.vx;
        v.y = it.vy;
        v.z = it.vz;
        v.w = '0;
        if (it.mode == MODE_FRAME)
            prod = quat_mul(quat_mul(cj, v), q);
        else
            prod = quat_mul(quat_mul(q, v), cj);
        ax = round_clip(prod.x);
        ay = round_clip(prod.y);
        az = round_clip(prod.z);
        r.ox = ax.val;
        r.oy = ay.val;
        r.oz = az.val;
        r.sat = ax.clip | ay.clip | az.clip;
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        n_errors++;
        $display("mismatch: %s", what);
    endtask

    task automatic queue_vector(input t_word qx, input t_word qy, input t_word qz,
                                input t_word qw, input t_word vx, input t_word vy,
                                input t_word vz, input t_mode mode, input logic hold);
        t_rot_item it;
        it.qx = qx;
        it.qy = qy;
        it.qz = qz;
        it.qw = qw;
        it.vx = vx;
        it.vy = vy;
        it.vz = vz;
        it.mode = mode;
        it.hold = hold;
        vectors_to_send.push_back(it);
    endtask

    function automatic t_word edge_word();
        case ($urandom_range(7, 0))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return -1;
            4: return 1;
            5: return 32'sd1073741824;
            6: return -32'sd1073741824;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_word small_word();
        return t_word'(int'($urandom_range(2000, 0)) - 1000);
    endfunction

    // sender: bursts of random length, random gaps, one word per handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                rotations_due.push_back(rotate_vector(cur_item));
                if (cur_item.mode == MODE_FRAME)
                    n_frame++;
                else
                    n_inverse++;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (vectors_to_send.size() == 0 ||
                             (vectors_to_send[0].hold && rotations_due.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    cur_item <= vectors_to_send[0];
                    s_data <= {vectors_to_send[0].vz, vectors_to_send[0].vy,
                               vectors_to_send[0].vx, vectors_to_send[0].qw,
                               vectors_to_send[0].qz, vectors_to_send[0].qy,
                               vectors_to_send[0].qx};
                    s_user <= vectors_to_send[0].mode;
                    s_valid <= 1'b1;
                    void'(vectors_to_send.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(24, 1);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver: switch stall style at random whenever the cycle counter's low bits wrap
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc[6:0] == 7'd127)
            rx_style <= $urandom_range(3, 0);
        case (rx_style)
            0: m_ready <= 1'b1;
            1: m_ready <= (rx_cyc % 3) == 0;
            2: m_ready <= 1'($urandom_range(1, 0));
            default: m_ready <= rx_cyc[4:0] >= 5'd20;
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_rot_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (rotations_due.size() == 0) begin
                note_mismatch($sformatf("unexpected word %h", o_m_axis_tdata));
            end else begin
                want = rotations_due.pop_front();
                n_checked++;
                if (o_m_axis_tuser[0])
                    n_clipped++;
                if (o_m_axis_tdata[31:0] !== want.ox)
                    note_mismatch($sformatf("out_x %h, want %h", o_m_axis_tdata[31:0],
                                            want.ox));
                if (o_m_axis_tdata[63:32] !== want.oy)
                    note_mismatch($sformatf("out_y %h, want %h", o_m_axis_tdata[63:32],
                                            want.oy));
                if (o_m_axis_tdata[95:64] !== want.oz)
                    note_mismatch($sformatf("out_z %h, want %h", o_m_axis_tdata[95:64],
                                            want.oz));
                if (o_m_axis_tuser[0] !== want.sat)
                    note_mismatch($sformatf("saturated %b, want %b", o_m_axis_tuser[0],
                                            want.sat));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= EDGE_WAIT) begin
            $display("timeout: no word moved for %0d cycles", EDGE_WAIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_word s45;
        t_word tie;
        real   ax;
        real   ay;
        real   az;
        real   aw;
        real   nrm;
        t_mode md;
        s45 = 32'sd759250125;
        tie = 32'sd536870912;

        for (int m = 0; m < 2; m++) begin
            md = t_mode'(m);
            queue_vector(0, 0, 0, 32'sd1073741824, WORD_MAX, WORD_MIN, 1, md, 1'b0);
            queue_vector(0, 0, s45, s45, 1000000, -2000000, 3000000, md, 1'b0);
            queue_vector(s45, 0, 0, s45, WORD_MAX, WORD_MIN, WORD_MAX, md, 1'b0);
            // |q|^2 of four: x just overflows, y lands exactly on the minimum
            queue_vector(0, 0, 0, WORD_MIN, tie, -tie, 0, md, m == 0);
            queue_vector(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                         WORD_MIN, md, 1'b0);
            queue_vector(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN,
                         WORD_MAX, md, 1'b0);
            queue_vector(32'sd1073741824, 0, 0, 0, 5, 6, 7, md, 1'b0);
        end
        queue_vector(0, 0, 0, 0, WORD_MAX, WORD_MAX, WORD_MAX, MODE_FRAME, 1'b0);
        // exact halves: ties go toward plus infinity
        queue_vector(0, 0, 0, 32'sd32768, tie, -tie, 3 * tie, MODE_FRAME, 1'b0);
        queue_vector(0, 0, 0, 32'sd32768, -3 * tie, tie + 1, -tie - 1, MODE_INVERSE, 1'b0);
        queue_vector(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1, -1, 0, MODE_FRAME, 1'b0);
        queue_vector(-1, -1, -1, -1, WORD_MAX, WORD_MAX, WORD_MIN, MODE_INVERSE, 1'b0);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            t_rot_item it;
            it.mode = t_mode'($urandom_range(1, 0));
            it.hold = (i % 150) == 149;
            case ($urandom_range(9, 0))
                0, 1, 2, 3: begin
                    ax = $urandom_range(2000, 0);
                    ay = $urandom_range(2000, 0);
                    az = $urandom_range(2000, 0);
                    aw = $urandom_range(2000, 0);
                    ax = ax - 1000.0;
                    ay = ay - 1000.0;
                    az = az - 1000.0;
                    aw = aw - 1000.0;
                    nrm = $sqrt(ax * ax + ay * ay + az * az + aw * aw);
                    if (nrm < 1.0) begin
                        ax = 0.0;
                        ay = 0.0;
                        az = 0.0;
                        aw = 1.0;
                        nrm = 1.0;
                    end
                    it.qx = $rtoi(ax / nrm * 1073741823.0);
                    it.qy = $rtoi(ay / nrm * 1073741823.0);
                    it.qz = $rtoi(az / nrm * 1073741823.0);
                    it.qw = $rtoi(aw / nrm * 1073741823.0);
                end
                4, 5, 6: begin
                    it.qx = $urandom;
                    it.qy = $urandom;
                    it.qz = $urandom;
                    it.qw = $urandom;
                end
                7: begin
                    it.qx = small_word();
                    it.qy = small_word();
                    it.qz = small_word();
                    it.qw = small_word();
                end
                default: begin
                    it.qx = edge_word();
                    it.qy = edge_word();
                    it.qz = edge_word();
                    it.qw = edge_word();
                end
            endcase
            case ($urandom_range(3, 0))
                0: begin
                    it.vx = small_word();
                    it.vy = small_word();
                    it.vz = small_word();
                end
                1: begin
                    it.vx = edge_word();
                    it.vy = edge_word();
                    it.vz = edge_word();
                end
                default: begin
                    it.vx = $urandom;
                    it.vy = $urandom;
                    it.vz = $urandom;
                end
            endcase
            vectors_to_send.push_back(it);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (vectors_to_send.size() != 0 || s_valid || rotations_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rotations_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", rotations_due.size()));

        $display("covered %0d rotations: %0d frame, %0d inverse, %0d checked",
                 n_frame + n_inverse, n_frame, n_inverse, n_checked);
        $display("%0d results clipped, %0d mismatches", n_clipped, n_errors);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qvr_pkg.sv
rtl/core/qvr_quad_mul.sv
rtl/core/qvr_matrix.sv
rtl/core/qvr_mat_vec.sv
rtl/core/qvr_round_sat.sv
rtl/core/quaternion_vector_frame_rotation_top.sv
tb/tb_top.sv
